>>> src/crc_pkg.sv
// Shared types and constants for the Catmull-Rom curve evaluator.
// Holds the request and result beat layouts, status codes and datapath widths.
// No dependencies.
package crc_pkg;

	localparam int COORD_W = 32;
	localparam int INDEX_W = 6;
	localparam int RATIO_W = 16;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;
	localparam int ACC_W   = 40;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FEW   = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic                      req_type;
		logic [INDEX_W-1:0]        knot_index;
		logic signed [COORD_W-1:0] knot_x;
		logic signed [COORD_W-1:0] knot_y;
		logic signed [COORD_W-1:0] knot_z;
		logic [RATIO_W-1:0]        curve_ratio;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic [STAT_W-1:0]         status;
	} res_t;

	typedef struct packed {
		logic              valid;
		logic              eval;
		logic [STAT_W-1:0] status;
	} ctl_t;

endpackage

>>> src/crc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module crc_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/crc_axis.sv
// One axis of the Catmull-Rom evaluator: coefficients, three Horner steps and
// the final rounded halving with saturation. Depends on crc_pkg.
module crc_axis (
	input  logic                               clk,
	input  logic signed [crc_pkg::COORD_W-1:0] p0,
	input  logic signed [crc_pkg::COORD_W-1:0] p1,
	input  logic signed [crc_pkg::COORD_W-1:0] p2,
	input  logic signed [crc_pkg::COORD_W-1:0] p3,
	input  logic [crc_pkg::RATIO_W-1:0]        t,
	output logic signed [crc_pkg::COORD_W-1:0] point
);

	localparam int AW = crc_pkg::ACC_W;
	localparam int TW = crc_pkg::RATIO_W;
	localparam int PW = AW + TW + 1;
	localparam int HW = AW - 1;
	localparam int CW = crc_pkg::COORD_W;

	// Multiply by t in Q0.16, round to nearest with ties toward plus infinity.
	function automatic logic signed [AW-1:0] mul_t(input logic signed [AW-1:0] v,
		input logic [TW-1:0] f);
		logic signed [PW-1:0] prod;
		prod = v * $signed({1'b0, f});
		prod = prod + $signed(PW'(32768));
		return prod[AW+TW-1:TW];
	endfunction

	logic signed [AW-1:0] e0, e1, e2, e3;
	logic signed [AW-1:0] a_s4, b_s4, c_s4, d_s4;
	logic [TW-1:0]        t_s4, t_s5, t_s6;
	logic signed [AW-1:0] a_s5, b_s5, acc_s5;
	logic signed [AW-1:0] a_s6, acc_s6;
	logic signed [AW-1:0] acc_s7;
	logic signed [AW-1:0] rnd;
	logic signed [HW-1:0] half;

	assign e0 = AW'(p0);
	assign e1 = AW'(p1);
	assign e2 = AW'(p2);
	assign e3 = AW'(p3);

	always_ff @(posedge clk) begin
		a_s4   <= e1 + e1;
		b_s4   <= e2 - e0;
		c_s4   <= (e0 + e0) - (e1 * 5) + (e2 * 4) - e3;
		d_s4   <= e3 - e0 + (e1 * 3) - (e2 * 3);
		t_s4   <= t;

		acc_s5 <= mul_t(d_s4, t_s4) + c_s4;
		b_s5   <= b_s4;
		a_s5   <= a_s4;
		t_s5   <= t_s4;

		acc_s6 <= mul_t(acc_s5, t_s5) + b_s5;
		a_s6   <= a_s5;
		t_s6   <= t_s5;

		acc_s7 <= mul_t(acc_s6, t_s6) + a_s6;
	end

	assign rnd  = acc_s7 + AW'(1);
	assign half = rnd[AW-1:1];

	always_comb begin
		if (half[HW-1:CW-1] == {(HW-CW+1){1'b0}} ||
			half[HW-1:CW-1] == {(HW-CW+1){1'b1}}) begin
			point = half[CW-1:0];
		end else if (half[HW-1]) begin
			point = {1'b1, {(CW-1){1'b0}}};
		end else begin
			point = {1'b0, {(CW-1){1'b1}}};
		end
	end

endmodule

>>> src/catmull_rom_curve_eval_core.sv
// Uniform Catmull-Rom spline evaluator over a store of 3-D knots.
// An accepted item passes ctl_s1 to ctl_s7 and the output register, then shows
// its result beat with done high. Throughput: one item per cycle, busy stays low.
// Four copies of the knot store give the four neighboring knots in a single read.
// Reset clears count_q and all valid bits; knot store contents are undefined.
// Depends on crc_pkg, crc_ram and crc_axis.
module catmull_rom_curve_eval_core #(
	parameter int MAX_KNOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  crc_pkg::req_t                req,
	input  logic                         cfg_we,
	input  logic [crc_pkg::COUNT_W-1:0]  cfg_wdata,
	output logic                         done,
	output crc_pkg::res_t                res
);

	localparam int AW  = $clog2(MAX_KNOTS);
	localparam int CW  = crc_pkg::COORD_W;
	localparam int RW  = crc_pkg::RATIO_W;
	localparam int NW  = crc_pkg::COUNT_W;
	localparam int PSW = RW + NW;
	localparam int DW  = 3 * CW;

	// The receiver cannot stall and the pipeline never blocks, so every start is taken.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Knot count register; user writes it only while the pipeline is empty, unenforced.
	logic [NW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Request decode. A write in range goes into all four store copies at once,
	// after the wr_s1 and wr_s2 registers. An evaluation accepted together with it
	// would read the store at the same edge, after ratio_s1 and seg_s2, so every
	// evaluation sees exactly the writes accepted before it and none accepted after it.
	logic                        idx_ok;
	logic [AW+crc_pkg::INDEX_W-1:0] idx_wide;
	logic                        wr_en;
	logic [crc_pkg::STAT_W-1:0]  status_in;

	assign idx_ok   = 32'(req.knot_index) < 32'(MAX_KNOTS);
	assign idx_wide = (AW + crc_pkg::INDEX_W)'(req.knot_index);
	assign wr_en    = accept && req.req_type == crc_pkg::REQ_WRITE && idx_ok;

	always_comb begin
		if (req.req_type == crc_pkg::REQ_WRITE) begin
			status_in = idx_ok ? crc_pkg::STATUS_OK : crc_pkg::STATUS_RANGE;
		end else if (count_q < NW'(4)) begin
			status_in = crc_pkg::STATUS_FEW;
		end else if (32'(count_q) > 32'(MAX_KNOTS)) begin
			status_in = crc_pkg::STATUS_RANGE;
		end else begin
			status_in = crc_pkg::STATUS_OK;
		end
	end

	// Knot writes travel two stages before they reach the store.
	logic          wr_s1, wr_s2;
	logic [AW-1:0] waddr_s1, waddr_s2;
	logic [DW-1:0] wdata_s1, wdata_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			wr_s2 <= 1'b0;
		end else begin
			wr_s1 <= wr_en;
			wr_s2 <= wr_s1;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= idx_wide[AW-1:0];
		waddr_s2 <= waddr_s1;
		wdata_s1 <= {req.knot_x, req.knot_y, req.knot_z};
		wdata_s2 <= wdata_s1;
	end

	// Control travels alongside the datapath, one stage register per cycle.
	crc_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [RW-1:0] ratio_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s1 <= '{valid: accept, eval: req.req_type == crc_pkg::REQ_EVAL,
				status: status_in};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		ratio_s1 <= req.curve_ratio;
	end

	// Stage 1: position along the curve, ratio times (count - 3). The integer
	// part selects the segment, the fraction is the local parameter t.
	logic [PSW-1:0] pos;
	logic [NW-1:0]  seg_s2;
	logic [RW-1:0]  t_s2, t_s3;

	assign pos = PSW'(ratio_s1) * PSW'(count_q - NW'(3));

	always_ff @(posedge clk) begin
		seg_s2 <= pos[PSW-1:RW];
		t_s2   <= pos[RW-1:0];
		t_s3   <= t_s2;
	end

	// Stage 2: knot reads. Copy k of the store is read at segment + k; for a
	// valid evaluation these addresses never pass the last knot in use.
	logic [DW-1:0] knot_s3 [4];

	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [AW+NW:0] addr_sum;

		assign addr_sum = (AW + NW + 1)'(seg_s2) + (AW + NW + 1)'(k);

		crc_ram #(
			.WIDTH(DW),
			.DEPTH(MAX_KNOTS)
		) u_ram (
			.clk  (clk),
			.we   (wr_s2),
			.waddr(waddr_s2),
			.wdata(wdata_s2),
			.raddr(addr_sum[AW-1:0]),
			.rdata(knot_s3[k])
		);
	end

	// Stages 3 to 7: one Horner pipeline per axis.
	logic signed [CW-1:0] pt_x, pt_y, pt_z;

	crc_axis u_axis_x (
		.clk  (clk),
		.p0   (knot_s3[0][DW-1:2*CW]),
		.p1   (knot_s3[1][DW-1:2*CW]),
		.p2   (knot_s3[2][DW-1:2*CW]),
		.p3   (knot_s3[3][DW-1:2*CW]),
		.t    (t_s3),
		.point(pt_x)
	);

	crc_axis u_axis_y (
		.clk  (clk),
		.p0   (knot_s3[0][2*CW-1:CW]),
		.p1   (knot_s3[1][2*CW-1:CW]),
		.p2   (knot_s3[2][2*CW-1:CW]),
		.p3   (knot_s3[3][2*CW-1:CW]),
		.t    (t_s3),
		.point(pt_y)
	);

	crc_axis u_axis_z (
		.clk  (clk),
		.p0   (knot_s3[0][CW-1:0]),
		.p1   (knot_s3[1][CW-1:0]),
		.p2   (knot_s3[2][CW-1:0]),
		.p3   (knot_s3[3][CW-1:0]),
		.t    (t_s3),
		.point(pt_z)
	);

	// Output register. Writes and flagged evaluations return zero points.
	logic          done_q;
	crc_pkg::res_t res_q;
	logic          show_pt;

	assign show_pt = ctl_s7.eval && ctl_s7.status == crc_pkg::STATUS_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s7.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q.point_x <= show_pt ? pt_x : '0;
		res_q.point_y <= show_pt ? pt_y : '0;
		res_q.point_z <= show_pt ? pt_z : '0;
		res_q.status  <= ctl_s7.status;
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##8 done)
		else $error("accepted beat did not produce a result beat");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 8))
		else $error("result beat without an accepted request");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status != crc_pkg::STATUS_OK |->
			res.point_x == '0 && res.point_y == '0 && res.point_z == '0)
		else $error("flagged result carries a nonzero point");

	a_few_knots: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid && ctl_s1.eval && ctl_s1.status == crc_pkg::STATUS_OK |->
			count_q >= NW'(4))
		else $error("evaluation passed with fewer than four knots");
`endif

endmodule
